### src/p2p_pkg.sv
package p2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int MAX_EXPR_LEN_DEF = 64;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FIRST    = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR = 3'd2;
    localparam logic [2:0] ST_TAIL     = 3'd3;
    localparam logic [2:0] ST_RATIO    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_EXCESS   = 3'd6;

    typedef struct packed {
        logic accept;
        logic step;
        logic pop;
        logic load;
        logic end_item;
    } cmd_t;

    typedef struct packed {
        logic need_out;
        logic top_cnt;
        logic level_one;
        logic rd_cnt;
        logic last;
        logic out_free;
    } sts_t;

endpackage

### src/p2p_ram.sv
module p2p_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/p2p_ctrl.sv
module p2p_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  p2p_pkg::sts_t  sts,
    output p2p_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PROC = 5'b00010,
        S_POP  = 5'b00100,
        S_LOAD = 5'b01000,
        S_END  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC: begin
                if (!sts.need_out || sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.need_out && sts.top_cnt) begin
                        state_next = S_POP;
                    end else if (sts.last) begin
                        state_next = S_END;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP: begin
                if (sts.out_free) begin
                    cmd.pop = 1'b1;
                    if (!sts.level_one) begin
                        state_next = S_LOAD;
                    end else if (sts.last) begin
                        state_next = S_END;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                if (sts.rd_cnt) begin
                    state_next = S_POP;
                end else if (sts.last) begin
                    state_next = S_END;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_END: begin
                if (sts.out_free) begin
                    cmd.end_item = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### src/p2p_datapath.sv
module p2p_datapath #(
    parameter int STACK_DEPTH = p2p_pkg::STACK_DEPTH_DEF,
    parameter int MAX_EXPR_LEN = p2p_pkg::MAX_EXPR_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [2:0]    m_tuser,
    input  p2p_pkg::cmd_t cmd,
    output p2p_pkg::sts_t sts
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int TOT_W = $clog2(MAX_EXPR_LEN + 1);

    logic [7:0]       char_reg;
    logic             last_reg;
    logic [1:0]       top_op_reg, top_op_next;
    logic             top_cnt_reg, top_cnt_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [TOT_W-1:0] opr_tot_reg, opr_tot_next;
    logic [TOT_W-1:0] opd_tot_reg, opd_tot_next;
    logic             first_reg, first_next;
    logic [1:0]       flags_reg, flags_next;
    logic [2:0]       err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic [2:0]       out_status_reg, out_status_next;

    logic             is_op;
    logic             is_opd;
    logic [1:0]       code;
    logic [2:0]       new_err;
    logic [TOT_W:0]   tot_sum;
    logic [2:0]       fin_err;
    logic [7:0]       top_char;
    logic             out_free;
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [2:0]       ram_rd_data;

    always_comb begin
        is_op = 1'b1;
        code = p2p_pkg::OP_ADD;
        unique case (char_reg)
            p2p_pkg::CH_PLUS:  code = p2p_pkg::OP_ADD;
            p2p_pkg::CH_MINUS: code = p2p_pkg::OP_SUB;
            p2p_pkg::CH_STAR:  code = p2p_pkg::OP_MUL;
            p2p_pkg::CH_SLASH: code = p2p_pkg::OP_DIV;
            default:           is_op = 1'b0;
        endcase
        unique case (top_op_reg)
            p2p_pkg::OP_ADD: top_char = p2p_pkg::CH_PLUS;
            p2p_pkg::OP_SUB: top_char = p2p_pkg::CH_MINUS;
            p2p_pkg::OP_MUL: top_char = p2p_pkg::CH_STAR;
            default:         top_char = p2p_pkg::CH_SLASH;
        endcase
    end

    assign is_opd = (char_reg >= 8'h61 && char_reg <= 8'h7A)
                 || (char_reg >= 8'h41 && char_reg <= 8'h5A)
                 || (char_reg >= 8'h30 && char_reg <= 8'h39);
    assign tot_sum = {1'b0, opr_tot_reg} + {1'b0, opd_tot_reg};

    always_comb begin
        priority if (first_reg && !is_op) begin
            new_err = p2p_pkg::ST_FIRST;
        end else if (!is_op && !is_opd) begin
            new_err = p2p_pkg::ST_BAD_CHAR;
        end else if (tot_sum >= (TOT_W + 1)'(MAX_EXPR_LEN)) begin
            new_err = p2p_pkg::ST_OVERFLOW;
        end else if (is_op && level_reg >= LVL_W'(STACK_DEPTH)) begin
            new_err = p2p_pkg::ST_OVERFLOW;
        end else if (!is_op && level_reg == '0) begin
            new_err = p2p_pkg::ST_EXCESS;
        end else begin
            new_err = p2p_pkg::ST_OK;
        end
    end

    always_comb begin
        priority if (err_reg != p2p_pkg::ST_OK) begin
            fin_err = err_reg;
        end else if (flags_reg != 2'b11) begin
            fin_err = p2p_pkg::ST_TAIL;
        end else if ({1'b0, opr_tot_reg} + (TOT_W + 1)'(1) != {1'b0, opd_tot_reg}) begin
            fin_err = p2p_pkg::ST_RATIO;
        end else begin
            fin_err = p2p_pkg::ST_OK;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    assign sts.need_out = (err_reg == p2p_pkg::ST_OK) && (new_err == p2p_pkg::ST_OK) && !is_op;
    assign sts.top_cnt = top_cnt_reg;
    assign sts.level_one = (level_reg == LVL_W'(1));
    assign sts.rd_cnt = ram_rd_data[0];
    assign sts.last = last_reg;
    assign sts.out_free = out_free;

    assign ram_wr_en = cmd.step && (err_reg == p2p_pkg::ST_OK)
                    && (new_err == p2p_pkg::ST_OK) && is_op && (level_reg != '0);
    assign ram_rd_en = cmd.pop && (level_reg != LVL_W'(1));

    p2p_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(level_reg - LVL_W'(1))),
        .wr_data ({top_op_reg, top_cnt_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (ADDR_W'(level_reg - LVL_W'(2))),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        top_op_next = top_op_reg;
        top_cnt_next = top_cnt_reg;
        level_next = level_reg;
        opr_tot_next = opr_tot_reg;
        opd_tot_next = opd_tot_reg;
        first_next = first_reg;
        flags_next = flags_reg;
        err_next = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_status_next = out_status_reg;

        if (cmd.step && err_reg == p2p_pkg::ST_OK) begin
            first_next = 1'b0;
            if (new_err != p2p_pkg::ST_OK) begin
                err_next = new_err;
            end else if (is_op) begin
                top_op_next = code;
                top_cnt_next = 1'b0;
                level_next = level_reg + LVL_W'(1);
                opr_tot_next = opr_tot_reg + TOT_W'(1);
                flags_next = {flags_reg[0], 1'b0};
            end else begin
                out_valid_next = 1'b1;
                out_char_next = char_reg;
                out_last_next = 1'b0;
                out_status_next = p2p_pkg::ST_OK;
                opd_tot_next = opd_tot_reg + TOT_W'(1);
                flags_next = {flags_reg[0], 1'b1};
                top_cnt_next = 1'b1;
            end
        end

        if (cmd.pop) begin
            out_valid_next = 1'b1;
            out_char_next = top_char;
            out_last_next = 1'b0;
            out_status_next = p2p_pkg::ST_OK;
            level_next = level_reg - LVL_W'(1);
            if (level_reg != LVL_W'(1)) begin
                top_cnt_next = 1'b0;
            end
        end

        if (cmd.load) begin
            top_op_next = ram_rd_data[2:1];
            top_cnt_next = 1'b1;
        end

        if (cmd.end_item) begin
            out_valid_next = 1'b1;
            out_char_next = p2p_pkg::CH_NEWLINE;
            out_last_next = 1'b1;
            out_status_next = fin_err;
            level_next = '0;
            opr_tot_next = '0;
            opd_tot_next = '0;
            first_next = 1'b1;
            flags_next = 2'b00;
            err_next = p2p_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            opr_tot_reg <= '0;
            opd_tot_reg <= '0;
            first_reg <= 1'b1;
            flags_reg <= 2'b00;
            err_reg <= p2p_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            level_reg <= level_next;
            opr_tot_reg <= opr_tot_next;
            opd_tot_reg <= opd_tot_next;
            first_reg <= first_next;
            flags_reg <= flags_next;
            err_reg <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        top_op_reg <= top_op_next;
        top_cnt_reg <= top_cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_char_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = out_status_reg;

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_status_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> out_status_reg == p2p_pkg::ST_OK)
        else $error("status code on a transfer that is not the end item");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> level_reg != '0)
        else $error("pop from an empty stack");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.end_item |=> level_reg == '0 && err_reg == p2p_pkg::ST_OK && first_reg)
        else $error("expression state not cleared after the end item");
`endif

endmodule

### src/prefix_to_postfix_converter_unit.sv
// Converts a prefix expression, one character per input transfer, into postfix.
// Input channel s_*: s_tdata carries the character, s_tlast marks the final one.
// Output channel m_*: m_tdata carries an emitted character, m_tlast marks the
// end item (a newline) and m_tuser carries its status code, zero on all others.
// An operator is taken in the idle state and pushed in the process state. An
// operand is taken likewise and, in the process state, written to the output
// register to be offered on m_tvalid. Every operator it completes adds a pop and
// a load state, since the pop reads the entry below from the stack RAM through
// its registered read port; the pop that empties the stack skips the load. The
// end item adds an end state. One character is handled at a time; s_tready is
// high only while the controller waits for the next character.
// Results leave through a single output register, so the next character is
// accepted while the last result still waits to be taken. While the receiver
// stalls, the controller holds in any state that writes the register until it frees.
// Reset clears the stack level, the counts, the error code and the output valid
// flag; stack RAM contents are left as they are and never read unwritten.
// After an error, later characters are swallowed until the end item.
module prefix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = p2p_pkg::STACK_DEPTH_DEF,
    parameter int MAX_EXPR_LEN = p2p_pkg::MAX_EXPR_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast,
    output logic [2:0] m_tuser    // [2:0] status
);

    p2p_pkg::cmd_t cmd;
    p2p_pkg::sts_t sts;

    p2p_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    p2p_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_EXPR_LEN (MAX_EXPR_LEN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

### test/prefix_to_postfix_converter_unit_tb.sv
`timescale 1ns / 1ps

module prefix_to_postfix_converter_unit_tb;

    import p2p_pkg::*;

    localparam int RANDOM_ITEMS   = 420;
    localparam int DIRECTED_ROWS  = 27;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [2:0] st;
    } char_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
        logic [2:0] st;
    } postfix_item_t;

    // Each typed row carries the status that its end item must report.
    localparam char_row_t DIRECTED [DIRECTED_ROWS] = '{
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {"a",      1'b0, 1'b0, ST_OK},
        {"b",      1'b1, 1'b1, ST_OK},
        {CH_MINUS, 1'b0, 1'b0, ST_OK},
        {CH_STAR,  1'b0, 1'b0, ST_OK},
        {"0",      1'b0, 1'b0, ST_OK},
        {"Z",      1'b0, 1'b0, ST_OK},
        {CH_SLASH, 1'b0, 1'b0, ST_OK},
        {"9",      1'b0, 1'b0, ST_OK},
        {"z",      1'b1, 1'b1, ST_OK},
        {8'hFF,    1'b1, 1'b1, ST_FIRST},
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {8'h00,    1'b0, 1'b0, ST_OK},
        {"a",      1'b1, 1'b1, ST_BAD_CHAR},
        {CH_STAR,  1'b0, 1'b0, ST_OK},
        {8'h0A,    1'b1, 1'b1, ST_BAD_CHAR},
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {"a",      1'b0, 1'b0, ST_OK},
        {CH_PLUS,  1'b1, 1'b1, ST_TAIL},
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {"a",      1'b0, 1'b0, ST_OK},
        {"b",      1'b1, 1'b1, ST_RATIO},
        {CH_PLUS,  1'b0, 1'b0, ST_OK},
        {"a",      1'b0, 1'b0, ST_OK},
        {"b",      1'b0, 1'b0, ST_OK},
        {"c",      1'b1, 1'b1, ST_EXCESS}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    char_row_t     stim_q[$];
    postfix_item_t postfix_q[$];

    int chars_sent   = 0;
    int chars_taken  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    bit held_once    = 1'b0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int idle_cycles  = 0;
    int fault_count  = 0;
    int results_seen = 0;

    logic [1:0] conv_ops  [STACK_DEPTH_DEF];
    logic [1:0] conv_done [STACK_DEPTH_DEF];
    int         conv_level   = 0;
    int         conv_n_ops   = 0;
    int         conv_n_opnds = 0;
    bit         conv_first   = 1'b1;
    logic [1:0] conv_recent  = 2'b00;
    logic [2:0] conv_err     = ST_OK;

    prefix_to_postfix_converter_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit is_operator(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
    endfunction

    function automatic bit is_operand(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [1:0] op_code_of(logic [7:0] c);
        case (c)
            CH_MINUS: return OP_SUB;
            CH_STAR:  return OP_MUL;
            CH_SLASH: return OP_DIV;
            default:  return OP_ADD;
        endcase
    endfunction

    function automatic logic [7:0] op_char_of(logic [1:0] code);
        case (code)
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            OP_DIV:  return CH_SLASH;
            default: return CH_PLUS;
        endcase
    endfunction

    // Advances the converter state by one character and queues what it emits.
    function automatic void convert_char(logic [7:0] c, logic last);
        bit was_first;
        if (conv_err == ST_OK) begin
            was_first  = conv_first;
            conv_first = 1'b0;
            if (was_first && !is_operator(c)) begin
                conv_err = ST_FIRST;
            end else if (!is_operator(c) && !is_operand(c)) begin
                conv_err = ST_BAD_CHAR;
            end else if (conv_n_ops + conv_n_opnds >= MAX_EXPR_LEN_DEF) begin
                conv_err = ST_OVERFLOW;
            end else if (is_operator(c)) begin
                if (conv_level >= STACK_DEPTH_DEF) begin
                    conv_err = ST_OVERFLOW;
                end else begin
                    conv_ops[conv_level]  = op_code_of(c);
                    conv_done[conv_level] = 2'd0;
                    conv_level++;
                    conv_n_ops++;
                    conv_recent = {conv_recent[0], 1'b0};
                end
            end else if (conv_level == 0) begin
                conv_err = ST_EXCESS;
            end else begin
                postfix_q.push_back('{c, 1'b0, ST_OK});
                conv_n_opnds++;
                conv_recent = {conv_recent[0], 1'b1};
                conv_done[conv_level - 1] = conv_done[conv_level - 1] + 2'd1;
                while (conv_level > 0 && conv_done[conv_level - 1] >= 2'd2) begin
                    postfix_q.push_back('{op_char_of(conv_ops[conv_level - 1]), 1'b0, ST_OK});
                    conv_level--;
                    if (conv_level > 0) begin
                        conv_done[conv_level - 1] = conv_done[conv_level - 1] + 2'd1;
                    end
                end
            end
        end
        if (last) begin
            if (conv_err == ST_OK) begin
                if (conv_recent != 2'b11) begin
                    conv_err = ST_TAIL;
                end else if (conv_n_ops + 1 != conv_n_opnds) begin
                    conv_err = ST_RATIO;
                end
            end
            postfix_q.push_back('{CH_NEWLINE, 1'b1, conv_err});
            conv_level   = 0;
            conv_n_ops   = 0;
            conv_n_opnds = 0;
            conv_first   = 1'b1;
            conv_recent  = 2'b00;
            conv_err     = ST_OK;
        end
    endfunction

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void build_expr(int n_ops, bit ops_first, ref logic [7:0] chars[$]);
        int need;
        int ops_left;
        need     = 1;
        ops_left = n_ops;
        chars.delete();
        while (need > 0) begin
            if (ops_left > 0 && (need == 1 || ops_first || $urandom_range(0, 1) == 1)) begin
                chars.push_back(op_char_of(2'($urandom_range(0, 3))));
                ops_left--;
                need++;
            end else begin
                chars.push_back(rand_operand());
                need--;
            end
        end
    endfunction

    function automatic void queue_expr(ref logic [7:0] chars[$]);
        foreach (chars[i]) begin
            stim_q.push_back({chars[i], 1'(i == chars.size() - 1), 1'b0, ST_OK});
        end
    endfunction

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endfunction

    initial begin
        logic [7:0] chars[$];
        int pick;
        int pos;
        foreach (DIRECTED[i]) begin
            stim_q.push_back(DIRECTED[i]);
        end
        // Deepest legal stack, a push onto a full stack, and an over-long expression.
        build_expr(31, 1'b1, chars);
        queue_expr(chars);
        build_expr(33, 1'b1, chars);
        queue_expr(chars);
        build_expr(40, 1'b0, chars);
        queue_expr(chars);
        while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                chars.delete();
                repeat ($urandom_range(1, 5)) chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_expr(($urandom_range(0, 7) == 0) ? $urandom_range(6, 20)
                                                       : $urandom_range(0, 5),
                           $urandom_range(0, 3) == 0, chars);
                if (pick < 28) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            pos = $urandom_range(0, chars.size() - 1);
                            chars[pos] = 8'($urandom_range(0, 255));
                        end
                        1: if (chars.size() > 1) void'(chars.pop_back());
                        2: chars.push_back(rand_operand());
                        default: chars.push_front(rand_operand());
                    endcase
                end
            end
            queue_expr(chars);
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (chars_sent < stim_q.size()) begin
                    s_tvalid   <= 1'b1;
                    s_tdata    <= stim_q[chars_sent].ch;
                    s_tlast    <= stim_q[chars_sent].last;
                    chars_sent <= chars_sent + 1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver runs in modes of random length; once, it holds off long enough
    // for the block to back up and stall its input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!held_once && chars_taken >= 300) begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      <= $urandom_range(0, 3);
                    rx_mode_left <= $urandom_range(8, 80);
                end else begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        postfix_item_t exp_item;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                convert_char(s_tdata, s_tlast);
                if (stim_q[chars_taken].typed) begin
                    void'(postfix_q.pop_back());
                    postfix_q.push_back('{CH_NEWLINE, 1'b1, stim_q[chars_taken].st});
                end
                chars_taken <= chars_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                if (postfix_q.size() == 0) begin
                    report_fault($sformatf("unexpected result: char %02h end %0b status %0d",
                                           m_tdata, m_tlast, m_tuser));
                end else begin
                    exp_item = postfix_q.pop_front();
                    if (m_tdata !== exp_item.ch || m_tlast !== exp_item.eoe ||
                            m_tuser !== exp_item.st) begin
                        report_fault($sformatf(
                            "result %0d: expected char %02h end %0b status %0d, got char %02h end %0b status %0d",
                            results_seen, exp_item.ch, exp_item.eoe, exp_item.st,
                            m_tdata, m_tlast, m_tuser));
                    end
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        wait (aresetn);
        do @(negedge aclk); while (chars_taken < stim_q.size() || postfix_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (postfix_q.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", postfix_q.size()));
        end
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
